// File: sv/sha1_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
package sha1_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // request passed from front to back through the queue
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } req_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] d;
    d = {x, x} << s;
    return d[63:32];
  endfunction

endpackage

// File: sv/sha1_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module sha1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/sha1_front.sv
// Request queue between the input channel and the hash core.
module sha1_front #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sha1_pkg::req_t      in_req,
  output logic                q_valid,
  input  logic                q_pop,
  output sha1_pkg::req_t      q_req
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha1_pkg::req_t   slot_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             push;

  assign in_stall = (cnt_r == (AW+1)'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_req    = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
    if (q_pop) rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
    if (push && !q_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) slot_r[wp_r] <= in_req;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue underflow");
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r == rp_r) |-> (cnt_r == '0 || cnt_r == (AW+1)'(DEPTH)))
    else $error("pointer mismatch");
`endif
endmodule

// File: sv/sha1_core.sv
// Byte buffering, padding, 80-round compression and digest output.
module sha1_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  sha1_pkg::req_t  q_req,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     out_digest_word,
  output logic [2:0]      out_word_index,
  output logic            out_last_word
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_ROUND = 7'b0001000,
    S_ADD   = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t       st_r, st_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [60:0]  total_r, total_nxt;
  logic         fin_r, fin_nxt;      // padding in progress
  logic [31:0]  h_r [5];
  logic [31:0]  v_r [5];
  logic [31:0]  w_r [16];
  logic [6:0]   rnd_r, rnd_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic [63:0]  bits_r;
  logic         ov_r, ov_nxt;

  // buffer RAM
  logic         ram_we;
  logic [5:0]   ram_waddr, ram_raddr;
  logic [7:0]   ram_wdata, ram_rdata;
  logic [6:0]   ld_r, ld_nxt;        // load counter, read address leads by one

  sha1_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // length bytes go only into the final block
  logic [7:0] pad_byte;
  always_comb begin
    if (fill_r >= 6'd56 && !ov_r) begin
      pad_byte = bits_r[8'd63 - {2'd0, fill_r[2:0], 3'd0} -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  logic accept;
  assign accept = (st_r == S_IDLE) && q_valid;
  assign q_pop  = accept;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_r;
    ram_wdata = q_req.data_byte;
    if (accept) begin
      if (q_req.cmd == sha1_pkg::CMD_ABSORB) begin
        ram_we = 1'b1;
      end else begin
        ram_we    = 1'b1;
        ram_wdata = sha1_pkg::PAD_BYTE;
      end
    end else if (st_r == S_PAD) begin
      ram_we    = 1'b1;
      ram_wdata = pad_byte;
    end
    ram_raddr = ld_r[5:0];
  end

  // round function
  logic [31:0] wt, fcur, kcur, tnew, wnew;
  logic [3:0]  slot;
  assign slot = rnd_r[3:0];
  always_comb begin
    wnew = sha1_pkg::rotl(w_r[slot + 4'd13] ^ w_r[slot + 4'd8] ^ w_r[slot + 4'd2]
                          ^ w_r[slot], 5'd1);
    wt   = (rnd_r >= 7'd16) ? wnew : w_r[slot];
    if (rnd_r < 7'd20) begin
      fcur = (v_r[1] & v_r[2]) | (~v_r[1] & v_r[3]); kcur = sha1_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      fcur = v_r[1] ^ v_r[2] ^ v_r[3]; kcur = sha1_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      fcur = (v_r[1] & v_r[2]) | (v_r[1] & v_r[3]) | (v_r[2] & v_r[3]);
      kcur = sha1_pkg::K2;
    end else begin
      fcur = v_r[1] ^ v_r[2] ^ v_r[3]; kcur = sha1_pkg::K3;
    end
    tnew = sha1_pkg::rotl(v_r[0], 5'd5) + v_r[4] + kcur + fcur + wt;
  end

  always_comb begin
    st_nxt    = st_r;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    fin_nxt   = fin_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    ld_nxt    = ld_r;
    ov_nxt    = ov_r;
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          fill_nxt = fill_r + 6'd1;
          if (q_req.cmd == sha1_pkg::CMD_ABSORB) begin
            total_nxt = total_r + 61'd1;
            if (fill_r == 6'd63) begin
              st_nxt = S_LOAD; ld_nxt = '0;
            end
          end else begin
            fin_nxt = 1'b1;
            if (fill_r == 6'd63) begin
              st_nxt = S_LOAD; ld_nxt = '0;
            end else begin
              st_nxt = S_PAD;
            end
          end
        end
      end
      S_PAD: begin
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          st_nxt = S_LOAD; ld_nxt = '0;
        end
      end
      S_LOAD: begin
        ld_nxt = ld_r + 7'd1;
        if (ld_r == 7'd64) begin
          st_nxt = S_ROUND; rnd_nxt = '0;
        end
      end
      S_ROUND: begin
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'd79) st_nxt = S_ADD;
      end
      S_ADD: begin
        // padding needs another block unless the length went in
        if (!fin_r) st_nxt = S_IDLE;
        else if (ov_r) begin
          st_nxt = S_PAD; ov_nxt = 1'b0;
        end else begin
          st_nxt = S_EMIT; idx_nxt = '0;
        end
      end
      S_EMIT: begin
        st_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd4) begin
            st_nxt = S_IDLE; fin_nxt = 1'b0; total_nxt = '0; fill_nxt = '0;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    // length field fits only if the 0x80 byte landed below offset 56
    if (accept && q_req.cmd == sha1_pkg::CMD_FINISH) ov_nxt = (fill_r >= 6'd56);
  end

  assign out_valid       = (st_r == S_WAIT);
  assign out_digest_word = h_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      fill_r  <= '0;
      total_r <= '0;
      fin_r   <= 1'b0;
      rnd_r   <= '0;
      idx_r   <= '0;
      ld_r    <= '0;
      ov_r    <= 1'b0;
      h_r[0]  <= sha1_pkg::H0_INIT;
      h_r[1]  <= sha1_pkg::H1_INIT;
      h_r[2]  <= sha1_pkg::H2_INIT;
      h_r[3]  <= sha1_pkg::H3_INIT;
      h_r[4]  <= sha1_pkg::H4_INIT;
    end else begin
      st_r    <= st_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      fin_r   <= fin_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      ld_r    <= ld_nxt;
      ov_r    <= ov_nxt;
      if (st_r == S_ADD) begin
        for (int i = 0; i < 5; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (st_r == S_WAIT && !out_stall && idx_r == 3'd4) begin
        h_r[0] <= sha1_pkg::H0_INIT;
        h_r[1] <= sha1_pkg::H1_INIT;
        h_r[2] <= sha1_pkg::H2_INIT;
        h_r[3] <= sha1_pkg::H3_INIT;
        h_r[4] <= sha1_pkg::H4_INIT;
      end
    end
    if (accept && q_req.cmd == sha1_pkg::CMD_FINISH) bits_r <= {total_r, 3'b000};
    if (st_r == S_LOAD && ld_r != 7'd0) begin
      // shift bytes: a finished word moves down when the next word starts
      if (ld_r[1:0] == 2'd1) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      end
      w_r[15] <= {w_r[15][23:0], ram_rdata};
    end
    if (st_r == S_LOAD && ld_r == 7'd64) begin
      for (int i = 0; i < 5; i++) v_r[i] <= h_r[i];
    end
    if (st_r == S_ROUND) begin
      if (rnd_r >= 7'd16) w_r[slot] <= wnew;
      v_r[4] <= v_r[3];
      v_r[3] <= v_r[2];
      v_r[2] <= sha1_pkg::rotl(v_r[1], 5'd30);
      v_r[1] <= v_r[0];
      v_r[0] <= tnew;
    end
  end

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r)) else $error("state not one-hot");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == S_IDLE) else $error("pop while busy");
  a_emit_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> fin_r) else $error("digest without finish");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_ROUND |-> rnd_r < 7'd80) else $error("round overrun");
`endif
endmodule

// File: sv/sha1_hash_engine.sv
// Top level of the SHA-1 hash engine.
// Input channel: in_valid/in_stall with in_cmd and in_data_byte. Absorb (cmd 0)
// appends one byte; finish (cmd 1) pads, compresses and emits the digest.
// Output channel: out_valid/out_stall with out_digest_word, out_word_index and
// out_last_word; a finish yields five words h0..h4, last_word set on h4.
// Requests pass through a short queue (QUEUE_DEPTH) into the core, which takes
// one request at a time.
// Absorb: the byte is written to the buffer RAM; when it completes a 64-byte
// block, the schedule is loaded from the buffer RAM, then 80 rounds and an add.
// Finish: one padding byte per cycle up to the block end, one or two block
// compressions, then a setup state and one digest word per cycle while
// out_stall is low.
// The core takes no new request while it loads and compresses a block; the
// single buffer RAM read port and the one-round-per-cycle loop limit throughput.
// Reset (synchronous, rst_n low) empties the queue, loads the initial chaining
// words and clears length and fill counts.
// While out_stall is high the current digest word holds; the core waits and
// the queue fills, then in_stall rises.
module sha1_hash_engine #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  sha1_pkg::req_t in_req, q_req;
  logic           q_valid, q_pop;

  assign in_req.cmd       = in_cmd;
  assign in_req.data_byte = in_data_byte;

  sha1_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
  );

  sha1_core u_core (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );
endmodule
